>>> rtl/core/bsmt_pkg.sv
`default_nettype none

package bsmt_pkg;

    // Default sizing
    localparam int ENTRIES_DEF    = 8;
    localparam int PROCESSES_DEF  = 64;
    localparam int PAGE_BYTES_DEF = 4096;

    // Fixed field widths
    localparam int OP_W     = 3;
    localparam int PID_W    = 6;
    localparam int SIDX_W   = 4;
    localparam int BASE_W   = 20;
    localparam int CNT_W    = 8;
    localparam int ADDR_W   = 32;
    localparam int FOUND_W  = 3;
    localparam int OFFSET_W = 21;

    localparam logic [BASE_W-1:0] DEFAULT_BASE  = 20'd4096;
    localparam logic [CNT_W-1:0]  MAX_PAGES_RST = 8'd128;
    localparam int                OFFSET_LIMIT  = 1048575;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_ALLOC  = 3'd1;
    localparam logic [OP_W-1:0] OP_FREE   = 3'd2;
    localparam logic [OP_W-1:0] OP_MAP    = 3'd3;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd4;
    localparam logic [OP_W-1:0] OP_UNMAP  = 3'd5;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture the input beat
        logic search;  // run the table searches and checks
        logic commit;  // update the table and load the result register
    } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/bsmt_req_if.sv
`default_nettype none

interface bsmt_req_if;
    logic                                valid;
    logic                                ready;
    logic [bsmt_pkg::OP_W-1:0]           operation;
    logic [bsmt_pkg::PID_W-1:0]          process_id;
    logic [bsmt_pkg::SIDX_W-1:0]         store_index;
    logic [bsmt_pkg::BASE_W-1:0]         base_page;
    logic [bsmt_pkg::CNT_W-1:0]          page_count;
    logic [bsmt_pkg::ADDR_W-1:0]         virtual_address;

    modport source (
        output valid, operation, process_id, store_index, base_page, page_count,
               virtual_address,
        input  ready
    );

    modport sink (
        input  valid, operation, process_id, store_index, base_page, page_count,
               virtual_address,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/bsmt_rsp_if.sv
`default_nettype none

interface bsmt_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  result_status;
    logic [bsmt_pkg::FOUND_W-1:0]          found_index;
    logic signed [bsmt_pkg::OFFSET_W-1:0]  page_offset;

    modport source (
        output valid, result_status, found_index, page_offset,
        input  ready
    );

    modport sink (
        input  valid, result_status, found_index, page_offset,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/backing_store_map_table_unit.sv
// Backing-store map table: a small table of store entries, each with a mapped
// flag, a per-process user mask, base page, page count and shared flag.
// Channels: req carries one request beat (operation, process_id, store_index,
// base_page, page_count, virtual_address); rsp returns exactly one result
// beat per request (result_status, found_index, page_offset). Both are
// valid/ready; a beat moves on a rising edge with valid and ready high.
// cfg_write/cfg_data write max_pages; write it only while the block is idle.
// Path: the request is captured on acceptance, searched in the search state,
// and in the commit state the table is updated and the result register loaded.
// Overlap: the next request can be taken in the commit state of the one before,
// once the result register is free.
// Reset: all entries unmapped, masks clear, base page 4096, max_pages 128.
// No clearing pass is needed; the table is usable straight after reset.
// Stall: the result register holds its beat until taken; a commit waits for
// it to free up, and no new request is taken meanwhile.
`default_nettype none

module backing_store_map_table_unit #(
    parameter int ENTRIES    = bsmt_pkg::ENTRIES_DEF,
    parameter int PROCESSES  = bsmt_pkg::PROCESSES_DEF,
    parameter int PAGE_BYTES = bsmt_pkg::PAGE_BYTES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_write,
    input  wire logic [bsmt_pkg::CNT_W-1:0]  cfg_data,
    bsmt_req_if.sink                         req,
    bsmt_rsp_if.source                       rsp
);

    bsmt_pkg::cmd_t cmd;

    // Sequencer: owns the handshakes and the output valid flag
    bsmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // Table, searches, checks and the result payload register
    bsmt_dp #(
        .ENTRIES    (ENTRIES),
        .PROCESSES  (PROCESSES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .operation       (req.operation),
        .process_id      (req.process_id),
        .store_index     (req.store_index),
        .base_page       (req.base_page),
        .page_count      (req.page_count),
        .virtual_address (req.virtual_address),
        .result_status   (rsp.result_status),
        .found_index     (rsp.found_index),
        .page_offset     (rsp.page_offset)
    );

endmodule

`default_nettype wire

>>> rtl/core/bsmt_ctrl.sv
`default_nettype none

module bsmt_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output bsmt_pkg::cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;
    logic       accept;
    logic       commit;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_COMMIT) && slot_free);
    assign accept    = in_valid && in_ready;
    assign commit    = (state_reg == ST_COMMIT) && slot_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (slot_free)
                begin
                    state_next = accept ? ST_SEARCH : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cmd.load   = accept;
    assign cmd.search = (state_reg == ST_SEARCH);
    assign cmd.commit = commit;

`ifndef SYNTHESIS
    a_accept_to_search: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SEARCH))
        else $error("accepted beat did not enter search");

    a_search_to_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |=> (state_reg == ST_COMMIT))
        else $error("search did not advance to commit");

    a_commit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("commit did not present a result");

    a_commit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_COMMIT) && !slot_free) |=> (state_reg == ST_COMMIT))
        else $error("commit left while result register was full");
`endif

endmodule

`default_nettype wire

>>> rtl/core/bsmt_dp.sv
`default_nettype none

module bsmt_dp #(
    parameter int ENTRIES    = bsmt_pkg::ENTRIES_DEF,
    parameter int PROCESSES  = bsmt_pkg::PROCESSES_DEF,
    parameter int PAGE_BYTES = bsmt_pkg::PAGE_BYTES_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire bsmt_pkg::cmd_t                       cmd,
    input  wire logic                                 cfg_write,
    input  wire logic [bsmt_pkg::CNT_W-1:0]           cfg_data,
    input  wire logic [bsmt_pkg::OP_W-1:0]            operation,
    input  wire logic [bsmt_pkg::PID_W-1:0]           process_id,
    input  wire logic [bsmt_pkg::SIDX_W-1:0]          store_index,
    input  wire logic [bsmt_pkg::BASE_W-1:0]          base_page,
    input  wire logic [bsmt_pkg::CNT_W-1:0]           page_count,
    input  wire logic [bsmt_pkg::ADDR_W-1:0]          virtual_address,
    output logic                                      result_status,
    output logic [bsmt_pkg::FOUND_W-1:0]              found_index,
    output logic signed [bsmt_pkg::OFFSET_W-1:0]      page_offset
);

    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int MPID_W     = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int DIFF_W     = bsmt_pkg::ADDR_W + 2;
    localparam logic signed [DIFF_W-1:0] LIM_HI = DIFF_W'(bsmt_pkg::OFFSET_LIMIT);
    localparam logic signed [DIFF_W-1:0] LIM_LO = -LIM_HI;
    localparam logic signed [bsmt_pkg::OFFSET_W-1:0] OFS_HI =
        bsmt_pkg::OFFSET_W'(bsmt_pkg::OFFSET_LIMIT);

    // Captured request
    logic [bsmt_pkg::OP_W-1:0]    op_reg;
    logic [bsmt_pkg::PID_W-1:0]   pid_reg;
    logic [bsmt_pkg::SIDX_W-1:0]  sidx_reg;
    logic [bsmt_pkg::BASE_W-1:0]  base_in_reg;
    logic [bsmt_pkg::CNT_W-1:0]   cnt_reg;
    logic [bsmt_pkg::ADDR_W-1:0]  addr_reg;

    logic [bsmt_pkg::CNT_W-1:0]   max_pages_reg;

    // Table
    logic                         mapped_reg [ENTRIES];
    logic [PROCESSES-1:0]         mask_reg   [ENTRIES];
    logic [bsmt_pkg::BASE_W-1:0]  base_reg   [ENTRIES];
    logic [bsmt_pkg::CNT_W-1:0]   count_reg  [ENTRIES];
    logic                         shared_reg [ENTRIES];

    // Search results
    logic                         ok_reg;
    logic                         ok_next;
    logic [IDX_W-1:0]             sel_reg;
    logic [IDX_W-1:0]             sel_next;

    logic                         idx_ok;
    logic                         pid_ok;
    logic                         free_found;
    logic [IDX_W-1:0]             free_sel;
    logic                         user_hit;
    logic [IDX_W-1:0]             user_sel;
    logic [IDX_W-1:0]             wr_idx;
    logic [MPID_W-1:0]            bit_sel;

    logic [bsmt_pkg::BASE_W-1:0]  base_sel;
    logic [bsmt_pkg::ADDR_W:0]    page_ext;
    logic signed [DIFF_W-1:0]     diff;
    logic signed [bsmt_pkg::OFFSET_W-1:0] offset_sat;
    logic [IDX_W+2:0]             sel_ext;

    assign idx_ok  = {1'b0, sidx_reg} < (bsmt_pkg::SIDX_W + 1)'(ENTRIES);
    assign pid_ok  = {1'b0, pid_reg} < (bsmt_pkg::PID_W + 1)'(PROCESSES);
    assign wr_idx  = sidx_reg[IDX_W-1:0];
    assign bit_sel = pid_reg[MPID_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= operation;
            pid_reg     <= process_id;
            sidx_reg    <= store_index;
            base_in_reg <= base_page;
            cnt_reg     <= page_count;
            addr_reg    <= virtual_address;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pages_reg <= bsmt_pkg::MAX_PAGES_RST;
        end
        else if (cfg_write)
        begin
            max_pages_reg <= cfg_data;
        end
    end

    // Priority searches: lowest free entry and lowest entry holding the process
    always_comb
    begin
        free_found = 1'b0;
        free_sel   = '0;
        user_hit   = 1'b0;
        user_sel   = '0;
        for (int k = ENTRIES - 1; k >= 0; k--)
        begin
            if (!mapped_reg[k])
            begin
                free_found = 1'b1;
                free_sel   = IDX_W'(k);
            end
            if (pid_ok && mask_reg[k][bit_sel])
            begin
                user_hit = 1'b1;
                user_sel = IDX_W'(k);
            end
        end
    end

    always_comb
    begin
        ok_next  = 1'b0;
        sel_next = '0;
        unique case (op_reg)
            bsmt_pkg::OP_CLEAR:  ok_next = 1'b1;
            bsmt_pkg::OP_ALLOC:
            begin
                ok_next  = free_found;
                sel_next = free_sel;
            end
            bsmt_pkg::OP_FREE:   ok_next = idx_ok;
            bsmt_pkg::OP_MAP:
            begin
                ok_next = idx_ok && (cnt_reg != '0) && (cnt_reg <= max_pages_reg) && pid_ok;
            end
            bsmt_pkg::OP_LOOKUP,
            bsmt_pkg::OP_UNMAP:
            begin
                ok_next  = user_hit;
                sel_next = user_sel;
            end
            default:             ok_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg  <= 1'b0;
            sel_reg <= '0;
        end
        else if (cmd.search)
        begin
            ok_reg  <= ok_next;
            sel_reg <= sel_next;
        end
    end

    // Table update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ENTRIES; k++)
            begin
                mapped_reg[k] <= 1'b0;
                mask_reg[k]   <= '0;
                base_reg[k]   <= bsmt_pkg::DEFAULT_BASE;
                count_reg[k]  <= '0;
                shared_reg[k] <= 1'b0;
            end
        end
        else if (cmd.commit && ok_reg)
        begin
            unique case (op_reg)
                bsmt_pkg::OP_CLEAR:
                begin
                    for (int k = 0; k < ENTRIES; k++)
                    begin
                        mapped_reg[k] <= 1'b0;
                        mask_reg[k]   <= '0;
                        base_reg[k]   <= bsmt_pkg::DEFAULT_BASE;
                        count_reg[k]  <= '0;
                        shared_reg[k] <= 1'b0;
                    end
                end
                bsmt_pkg::OP_FREE:
                begin
                    mapped_reg[wr_idx] <= 1'b0;
                    mask_reg[wr_idx]   <= '0;
                    base_reg[wr_idx]   <= bsmt_pkg::DEFAULT_BASE;
                    count_reg[wr_idx]  <= '0;
                    shared_reg[wr_idx] <= 1'b0;
                end
                bsmt_pkg::OP_MAP:
                begin
                    mapped_reg[wr_idx]        <= 1'b1;
                    mask_reg[wr_idx][bit_sel] <= 1'b1;
                    base_reg[wr_idx]          <= base_in_reg;
                    count_reg[wr_idx]         <= cnt_reg;
                    shared_reg[wr_idx]        <= 1'b1;
                end
                bsmt_pkg::OP_UNMAP:
                begin
                    mapped_reg[sel_reg]        <= 1'b0;
                    mask_reg[sel_reg][bit_sel] <= 1'b0;
                    base_reg[sel_reg]          <= bsmt_pkg::DEFAULT_BASE;
                    count_reg[sel_reg]         <= '0;
                    shared_reg[sel_reg]        <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Page offset: address page minus entry base, saturated
    assign base_sel = base_reg[sel_reg];
    assign page_ext = {1'b0, addr_reg} >> PAGE_SHIFT;
    assign diff     = $signed({1'b0, page_ext})
                    - $signed({{(DIFF_W - bsmt_pkg::BASE_W){1'b0}}, base_sel});

    always_comb
    begin
        if (diff > LIM_HI)
        begin
            offset_sat = OFS_HI;
        end
        else if (diff < LIM_LO)
        begin
            offset_sat = -OFS_HI;
        end
        else
        begin
            offset_sat = $signed(diff[bsmt_pkg::OFFSET_W-1:0]);
        end
    end

    assign sel_ext = {3'b000, sel_reg};

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            result_status <= !ok_reg;
            found_index   <= '0;
            page_offset   <= '0;
            if (ok_reg && ((op_reg == bsmt_pkg::OP_ALLOC) || (op_reg == bsmt_pkg::OP_LOOKUP)
                           || (op_reg == bsmt_pkg::OP_UNMAP)))
            begin
                found_index <= sel_ext[bsmt_pkg::FOUND_W-1:0];
            end
            if (ok_reg && (op_reg == bsmt_pkg::OP_LOOKUP))
            begin
                page_offset <= offset_sat;
            end
        end
    end

endmodule

`default_nettype wire

>>> tb/testbench.sv
module testbench;
    import bsmt_pkg::*;

    // Sizing as built by the default parameters of the unit
    localparam int NUM_ENTRIES = ENTRIES_DEF;
    localparam int NUM_PROCS   = PROCESSES_DEF;
    localparam int PAGE_SIZE   = PAGE_BYTES_DEF;

    // Operation codes the unit does not define
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    // Result status codes
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    // Cycles without any beat before the run is declared hung. The slowest
    // legal stretch is a sender gap, a receiver stall and the pipe, plus a
    // short pause around a register write.
    localparam int IDLE_LIMIT    = 500;
    // Extra cycles to let the pipe settle once every result is back
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS   = 230;
    localparam int NUM_PHASES    = 4;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [PID_W-1:0]  pid;
        logic [SIDX_W-1:0] idx;
        logic [BASE_W-1:0] base;
        logic [CNT_W-1:0]  cnt;
        logic [ADDR_W-1:0] addr;
    } req_beat_t;

    typedef struct packed {
        logic                status;
        logic [FOUND_W-1:0]  found;
        logic [OFFSET_W-1:0] offset;
    } rsp_beat_t;

    // One row of the directed table: the request, and where the outcome is
    // plain from the spec, the result typed in by hand
    typedef struct {
        req_beat_t beat;
        bit        typed;
        rsp_beat_t want;
    } stim_row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_write;
    logic [CNT_W-1:0] cfg_data;

    bsmt_req_if req_ch ();
    bsmt_rsp_if rsp_ch ();

    backing_store_map_table_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Local copy of the table and of the page limit register
    logic                 map_flag    [NUM_ENTRIES];
    logic [NUM_PROCS-1:0] user_bits   [NUM_ENTRIES];
    logic [BASE_W-1:0]    base_pg     [NUM_ENTRIES];
    logic [CNT_W-1:0]     pg_count    [NUM_ENTRIES];
    logic                 shared_flag [NUM_ENTRIES];
    logic [CNT_W-1:0]     page_limit;

    rsp_beat_t pending_results [$];
    stim_row_t directed_rows [$];

    int  error_count   = 0;
    int  results_seen  = 0;
    int  requests_sent = 0;
    int  idle_cycles   = 0;
    bit  calm_stretch  = 1'b0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------

    function automatic void clear_slot(int k);
        map_flag[k]    = 1'b0;
        user_bits[k]   = '0;
        base_pg[k]     = DEFAULT_BASE;
        pg_count[k]    = '0;
        shared_flag[k] = 1'b0;
    endfunction

    // Lowest entry whose mask holds the process, -1 when none does.
    // Only the mask counts here, not the mapped flag.
    function automatic int first_holder(logic [PID_W-1:0] pid);
        int hit;
        hit = -1;
        for (int k = NUM_ENTRIES - 1; k >= 0; k--)
            if (user_bits[k][pid])
                hit = k;
        return hit;
    endfunction

    // Apply one request to the local table and return the result it gives
    function automatic rsp_beat_t apply_request(req_beat_t r);
        rsp_beat_t   res;
        int          hit;
        logic [31:0] vpage;
        longint      page_delta;
        res        = '0;
        res.status = ST_ERR;
        hit        = -1;
        case (r.op)
            OP_CLEAR:
            begin
                for (int k = 0; k < NUM_ENTRIES; k++)
                    clear_slot(k);
                res.status = ST_OK;
            end
            OP_ALLOC:
            begin
                for (int k = NUM_ENTRIES - 1; k >= 0; k--)
                    if (!map_flag[k])
                        hit = k;
                if (hit >= 0)
                begin
                    res.status = ST_OK;
                    res.found  = hit[FOUND_W-1:0];
                end
            end
            OP_FREE:
            begin
                if (r.idx < NUM_ENTRIES)
                begin
                    clear_slot(int'(r.idx));
                    res.status = ST_OK;
                end
            end
            OP_MAP:
            begin
                if (r.idx < NUM_ENTRIES && r.cnt != 0 && r.cnt <= page_limit
                    && r.pid < NUM_PROCS)
                begin
                    map_flag[r.idx]       = 1'b1;
                    user_bits[r.idx][r.pid] = 1'b1;
                    base_pg[r.idx]        = r.base;
                    pg_count[r.idx]       = r.cnt;
                    shared_flag[r.idx]    = 1'b1;
                    res.status            = ST_OK;
                end
            end
            OP_LOOKUP:
            begin
                hit = first_holder(r.pid);
                if (hit >= 0)
                begin
                    vpage = r.addr / PAGE_SIZE;
                    page_delta = $signed({32'd0, vpage}) - $signed({44'd0, base_pg[hit]});
                    if (page_delta > OFFSET_LIMIT)
                        page_delta = OFFSET_LIMIT;
                    if (page_delta < -OFFSET_LIMIT)
                        page_delta = -OFFSET_LIMIT;
                    res.status = ST_OK;
                    res.found  = hit[FOUND_W-1:0];
                    res.offset = page_delta[OFFSET_W-1:0];
                end
            end
            OP_UNMAP:
            begin
                if (r.pid < NUM_PROCS)
                    hit = first_holder(r.pid);
                if (hit >= 0)
                begin
                    // drop only this process's bit, the rest of the mask stays
                    map_flag[hit]         = 1'b0;
                    user_bits[hit][r.pid] = 1'b0;
                    base_pg[hit]          = DEFAULT_BASE;
                    pg_count[hit]         = '0;
                    shared_flag[hit]      = 1'b0;
                    res.status            = ST_OK;
                    res.found             = hit[FOUND_W-1:0];
                end
            end
            default:
            begin
                // undefined codes leave the table alone and report an error
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Reporting and checking
    // ------------------------------------------------------------------

    task automatic report_fault(input string msg);
        $display("MISMATCH: %s", msg);
        error_count++;
    endtask

    task automatic check_result(input rsp_beat_t got);
        rsp_beat_t want;
        results_seen++;
        if (pending_results.size() == 0)
        begin
            report_fault($sformatf("result beat %0d arrived with nothing outstanding",
                                   results_seen));
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.status !== want.status)
                report_fault($sformatf("result %0d status got %0b want %0b",
                                       results_seen, got.status, want.status));
            if (got.found !== want.found)
                report_fault($sformatf("result %0d found_index got %0d want %0d",
                                       results_seen, got.found, want.found));
            if (got.offset !== want.offset)
                report_fault($sformatf("result %0d page_offset got %0d want %0d",
                                       results_seen, $signed(got.offset),
                                       $signed(want.offset)));
        end
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Drive one request beat and hold it until taken. With no gap drawn the
    // valid stays high straight on from the previous beat.
    task automatic send_request(input req_beat_t beat, input bit typed,
                                input rsp_beat_t want);
        int        gap;
        rsp_beat_t predicted;
        gap = calm_stretch ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.operation       <= beat.op;
        req_ch.process_id      <= beat.pid;
        req_ch.store_index     <= beat.idx;
        req_ch.base_page       <= beat.base;
        req_ch.page_count      <= beat.cnt;
        req_ch.virtual_address <= beat.addr;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        // beat taken at this edge: advance the model
        predicted = apply_request(beat);
        pending_results.push_back(typed ? want : predicted);
        requests_sent++;
        // now and then switch to a run of back-to-back beats on both sides
        if (requests_sent % 40 == 0)
            calm_stretch = ($urandom_range(0, 3) == 0);
    endtask

    task automatic send_predicted(input req_beat_t beat);
        send_request(beat, 1'b0, '0);
    endtask

    // Drop valid, wait until every result is back and the pipe has settled
    task automatic drain_table;
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_page_limit(input logic [CNT_W-1:0] value);
        drain_table();
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write  <= 1'b0;
        page_limit = value;
    endtask

    function automatic stim_row_t mk_row(logic [OP_W-1:0] op, logic [PID_W-1:0] pid,
                                         logic [SIDX_W-1:0] idx, logic [BASE_W-1:0] base,
                                         logic [CNT_W-1:0] cnt, logic [ADDR_W-1:0] addr,
                                         bit typed, logic status, logic [FOUND_W-1:0] found);
        stim_row_t row;
        row.beat  = '{op, pid, idx, base, cnt, addr};
        row.typed = typed;
        row.want  = '{status, found, '0};
        return row;
    endfunction

    // Mostly a small pool of processes and in-range entries so that maps,
    // lookups and unmaps meet each other; the rest spans the full fields.
    function automatic req_beat_t make_random_request;
        req_beat_t r;
        int        w;
        r.pid  = ($urandom_range(0, 4) == 0) ? PID_W'($urandom_range(0, 63))
                                             : PID_W'($urandom_range(0, 7));
        r.idx  = ($urandom_range(0, 6) == 0) ? SIDX_W'($urandom_range(8, 15))
                                             : SIDX_W'($urandom_range(0, 7));
        r.cnt  = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(0, 255))
                                             : CNT_W'($urandom_range(1, page_limit));
        r.base = BASE_W'($urandom());
        r.addr = $urandom();
        w      = $urandom_range(0, 99);
        if (w < 2)
            r.op = OP_CLEAR;
        else if (w < 14)
            r.op = OP_ALLOC;
        else if (w < 26)
            r.op = OP_FREE;
        else if (w < 58)
            r.op = OP_MAP;
        else if (w < 80)
            r.op = OP_LOOKUP;
        else if (w < 96)
            r.op = OP_UNMAP;
        else
            r.op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        return r;
    endfunction

    // Map every entry in turn, then ask for a free one, which must fail
    task automatic fill_and_allocate;
        req_beat_t r;
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            r     = make_random_request();
            r.op  = OP_MAP;
            r.idx = k[SIDX_W-1:0];
            r.cnt = CNT_W'($urandom_range(1, page_limit));
            send_predicted(r);
        end
        r    = make_random_request();
        r.op = OP_ALLOC;
        send_predicted(r);
    endtask

    // ------------------------------------------------------------------
    // Response side: draw a stall per beat, then take it and check it
    // ------------------------------------------------------------------

    initial
    begin
        int        stall;
        rsp_beat_t got;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            stall = calm_stretch ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (rsp_ch.valid !== 1'b1)
                @(posedge clk);
            got = '{rsp_ch.result_status, rsp_ch.found_index, rsp_ch.page_offset};
            check_result(got);
        end
    end

    // Hang detection: count edges on which no beat moves on either channel
    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n                  <= 1'b0;
        cfg_write              <= 1'b0;
        cfg_data               <= MAX_PAGES_RST;
        req_ch.valid           <= 1'b0;
        req_ch.operation       <= OP_CLEAR;
        req_ch.process_id      <= '0;
        req_ch.store_index     <= '0;
        req_ch.base_page       <= '0;
        req_ch.page_count      <= '0;
        req_ch.virtual_address <= '0;

        for (int k = 0; k < NUM_ENTRIES; k++)
            clear_slot(k);
        page_limit = MAX_PAGES_RST;

        // Directed rows, run under the reset page limit of 128
        // empty table: nothing to find, nothing to unmap
        directed_rows.push_back(mk_row(OP_LOOKUP, 6'd0, 4'd0, 20'd0, 8'd0, 32'd0,
                                       1, ST_ERR, 3'd0));
        directed_rows.push_back(mk_row(OP_UNMAP, 6'd0, 4'd0, 20'd0, 8'd0, 32'd0,
                                       1, ST_ERR, 3'd0));
        directed_rows.push_back(mk_row(OP_ALLOC, 6'd0, 4'd0, 20'd0, 8'd0, 32'd0,
                                       1, ST_OK, 3'd0));
        directed_rows.push_back(mk_row(OP_MAP, 6'd0, 4'd0, 20'd0, 8'd1, 32'd0,
                                       1, ST_OK, 3'd0));
        // bad index at both ends of the invalid range
        directed_rows.push_back(mk_row(OP_MAP, 6'd1, 4'd8, 20'd5, 8'd1, 32'd0,
                                       1, ST_ERR, 3'd0));
        directed_rows.push_back(mk_row(OP_MAP, 6'd1, 4'd15, 20'd5, 8'd1, 32'd0,
                                       1, ST_ERR, 3'd0));
        // bad count: zero, and one past the limit
        directed_rows.push_back(mk_row(OP_MAP, 6'd63, 4'd1, 20'hFFFFF, 8'd0, 32'd0,
                                       1, ST_ERR, 3'd0));
        directed_rows.push_back(mk_row(OP_MAP, 6'd63, 4'd1, 20'hFFFFF, 8'd129, 32'd0,
                                       1, ST_ERR, 3'd0));
        directed_rows.push_back(mk_row(OP_MAP, 6'd63, 4'd1, 20'hFFFFF, 8'd128, 32'd0,
                                       1, ST_OK, 3'd0));
        // widest positive and negative page offsets
        directed_rows.push_back(mk_row(OP_LOOKUP, 6'd0, 4'd0, 20'd0, 8'd0, 32'hFFFFFFFF,
                                       0, ST_OK, 3'd0));
        directed_rows.push_back(mk_row(OP_LOOKUP, 6'd63, 4'd0, 20'd0, 8'd0, 32'd0,
                                       0, ST_OK, 3'd0));
        directed_rows.push_back(mk_row(OP_ALLOC, 6'd0, 4'd0, 20'd0, 8'd0, 32'd0,
                                       0, ST_OK, 3'd0));
        // undefined operations, then free at bad indexes and at a good one
        directed_rows.push_back(mk_row(OP_SPARE_A, 6'd0, 4'd0, 20'd0, 8'd1, 32'd0,
                                       1, ST_ERR, 3'd0));
        directed_rows.push_back(mk_row(OP_SPARE_B, 6'd63, 4'd15, 20'hFFFFF, 8'd255,
                                       32'hFFFFFFFF, 1, ST_ERR, 3'd0));
        directed_rows.push_back(mk_row(OP_FREE, 6'd0, 4'd8, 20'd0, 8'd0, 32'd0,
                                       1, ST_ERR, 3'd0));
        directed_rows.push_back(mk_row(OP_FREE, 6'd0, 4'd15, 20'd0, 8'd0, 32'd0,
                                       1, ST_ERR, 3'd0));
        directed_rows.push_back(mk_row(OP_FREE, 6'd0, 4'd1, 20'd0, 8'd0, 32'd0,
                                       1, ST_OK, 3'd0));
        // two processes share entry 2; unmap one, the other still finds it
        // even though the entry is no longer mapped
        directed_rows.push_back(mk_row(OP_MAP, 6'd5, 4'd2, 20'd12345, 8'd7, 32'd0,
                                       1, ST_OK, 3'd0));
        directed_rows.push_back(mk_row(OP_MAP, 6'd6, 4'd2, 20'd777, 8'd3, 32'd0,
                                       1, ST_OK, 3'd0));
        directed_rows.push_back(mk_row(OP_UNMAP, 6'd5, 4'd0, 20'd0, 8'd0, 32'd0,
                                       0, ST_OK, 3'd0));
        directed_rows.push_back(mk_row(OP_LOOKUP, 6'd6, 4'd0, 20'd0, 8'd0, 32'h01234567,
                                       0, ST_OK, 3'd0));
        directed_rows.push_back(mk_row(OP_UNMAP, 6'd0, 4'd0, 20'd0, 8'd0, 32'd0,
                                       0, ST_OK, 3'd0));
        // clear all, then the table is empty again
        directed_rows.push_back(mk_row(OP_CLEAR, 6'd0, 4'd0, 20'd0, 8'd0, 32'd0,
                                       1, ST_OK, 3'd0));
        directed_rows.push_back(mk_row(OP_ALLOC, 6'd0, 4'd0, 20'd0, 8'd0, 32'd0,
                                       1, ST_OK, 3'd0));
        directed_rows.push_back(mk_row(OP_LOOKUP, 6'd6, 4'd0, 20'd0, 8'd0, 32'h01234567,
                                       1, ST_ERR, 3'd0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].beat, directed_rows[i].typed,
                         directed_rows[i].want);

        // Random phases: the two extremes of the page limit, then arbitrary ones
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:       set_page_limit(8'd1);
                1:       set_page_limit(8'd255);
                default: set_page_limit(CNT_W'($urandom_range(1, 255)));
            endcase
            fill_and_allocate();
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_predicted(make_random_request());
        end

        // Hold until every result is back, then let the pipe settle
        drain_table();

        $display("summary: %0d requests, %0d results checked over %0d page limits",
                 requests_sent, results_seen, NUM_PHASES + 1);
        $display("summary: %0d mismatches", error_count);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/bsmt_pkg.sv
rtl/core/bsmt_req_if.sv
rtl/core/bsmt_rsp_if.sv
rtl/core/bsmt_ctrl.sv
rtl/core/bsmt_dp.sv
rtl/core/backing_store_map_table_unit.sv
tb/testbench.sv
